/* rtl/ocr_pkg.sv */
`timescale 1ns / 1ps

package ocr_pkg;

   // component format and limits
   localparam int OCR_W    = 18;
   localparam int OCR_VMAX = 131071;
   localparam int OCR_VMIN = -131072;

   localparam int OCR_COS_RESET = 60547;
   localparam int OCR_SIN_RESET = 25080;

   typedef logic signed [OCR_W-1:0] ocr_coord_type;

   // arrow codes
   localparam int OCR_DIR_W = 2;
   localparam logic [OCR_DIR_W-1:0] DIR_LEFT  = 2'd0;
   localparam logic [OCR_DIR_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [OCR_DIR_W-1:0] DIR_UP    = 2'd2;
   localparam logic [OCR_DIR_W-1:0] DIR_DOWN  = 2'd3;

   // register indexes
   localparam int OCR_CSR_IDX_W = 1;
   localparam logic [OCR_CSR_IDX_W-1:0] CSR_COS = 1'd0;
   localparam logic [OCR_CSR_IDX_W-1:0] CSR_SIN = 1'd1;

   // operand selects of the shared multiplier
   localparam int OCR_SEL_N = 16;
   localparam logic [3:0] SEL_P0  = 4'd0;
   localparam logic [3:0] SEL_P1  = 4'd1;
   localparam logic [3:0] SEL_P2  = 4'd2;
   localparam logic [3:0] SEL_A0  = 4'd3;
   localparam logic [3:0] SEL_A1  = 4'd4;
   localparam logic [3:0] SEL_A2  = 4'd5;
   localparam logic [3:0] SEL_K0  = 4'd6;
   localparam logic [3:0] SEL_K1  = 4'd7;
   localparam logic [3:0] SEL_K2  = 4'd8;
   localparam logic [3:0] SEL_D   = 4'd9;
   localparam logic [3:0] SEL_Q   = 4'd10;
   localparam logic [3:0] SEL_C   = 4'd11;
   localparam logic [3:0] SEL_S   = 4'd12;
   localparam logic [3:0] SEL_OMC = 4'd13;

   // accumulator destinations
   localparam logic [3:0] DST_NONE = 4'd0;
   localparam logic [3:0] DST_K0   = 4'd1;
   localparam logic [3:0] DST_K1   = 4'd2;
   localparam logic [3:0] DST_K2   = 4'd3;
   localparam logic [3:0] DST_D    = 4'd4;
   localparam logic [3:0] DST_Q    = 4'd5;
   localparam logic [3:0] DST_P0   = 4'd6;
   localparam logic [3:0] DST_P1   = 4'd7;
   localparam logic [3:0] DST_P2   = 4'd8;
   localparam logic [3:0] DST_N2   = 4'd9;

   // program entry points
   localparam int OCR_PC_W = 5;
   localparam logic [OCR_PC_W-1:0] PC_ROT  = 5'd0;
   localparam logic [OCR_PC_W-1:0] PC_TILT = 5'd19;

   typedef struct packed {
      logic [3:0] a_sel;
      logic [3:0] b_sel;
      logic       first;
      logic       sub;
      logic [3:0] dst;
      logic       last;
   } ocr_uop_type;

   function automatic ocr_uop_type ocr_mk(input logic [3:0] a, input logic [3:0] b,
                                          input logic first, input logic sub,
                                          input logic [3:0] dst, input logic last);
      ocr_uop_type u;
      u.a_sel = a;
      u.b_sel = b;
      u.first = first;
      u.sub   = sub;
      u.dst   = dst;
      u.last  = last;
      return u;
   endfunction

   // multiply-accumulate program: rotation of P about A, then tilt axis setup
   function automatic ocr_uop_type ocr_uop(input logic [OCR_PC_W-1:0] pc);
      ocr_uop_type u;
      unique case (pc)
         // k = a x p
         5'd0:  u = ocr_mk(SEL_A1, SEL_P2, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd1:  u = ocr_mk(SEL_A2, SEL_P1, 1'b0, 1'b1, DST_K0,   1'b0);
         5'd2:  u = ocr_mk(SEL_A2, SEL_P0, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd3:  u = ocr_mk(SEL_A0, SEL_P2, 1'b0, 1'b1, DST_K1,   1'b0);
         5'd4:  u = ocr_mk(SEL_A0, SEL_P1, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd5:  u = ocr_mk(SEL_A1, SEL_P0, 1'b0, 1'b1, DST_K2,   1'b0);
         // d = a . p, q = (1 - c) d
         5'd6:  u = ocr_mk(SEL_A0, SEL_P0, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd7:  u = ocr_mk(SEL_A1, SEL_P1, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd8:  u = ocr_mk(SEL_A2, SEL_P2, 1'b0, 1'b0, DST_D,    1'b0);
         5'd9:  u = ocr_mk(SEL_OMC, SEL_D, 1'b1, 1'b0, DST_Q,    1'b0);
         // p_i = s k_i + q a_i + c p_i
         5'd10: u = ocr_mk(SEL_S,  SEL_K0, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd11: u = ocr_mk(SEL_Q,  SEL_A0, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd12: u = ocr_mk(SEL_C,  SEL_P0, 1'b0, 1'b0, DST_P0,   1'b0);
         5'd13: u = ocr_mk(SEL_S,  SEL_K1, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd14: u = ocr_mk(SEL_Q,  SEL_A1, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd15: u = ocr_mk(SEL_C,  SEL_P1, 1'b0, 1'b0, DST_P1,   1'b0);
         5'd16: u = ocr_mk(SEL_S,  SEL_K2, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd17: u = ocr_mk(SEL_Q,  SEL_A2, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd18: u = ocr_mk(SEL_C,  SEL_P2, 1'b0, 1'b0, DST_P2,   1'b1);
         // tilt axis r = (-eye) x up, with P = eye and A = up
         5'd19: u = ocr_mk(SEL_P2, SEL_A1, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd20: u = ocr_mk(SEL_P1, SEL_A2, 1'b0, 1'b1, DST_K0,   1'b0);
         5'd21: u = ocr_mk(SEL_P0, SEL_A2, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd22: u = ocr_mk(SEL_P2, SEL_A0, 1'b0, 1'b1, DST_K1,   1'b0);
         5'd23: u = ocr_mk(SEL_P1, SEL_A0, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd24: u = ocr_mk(SEL_P0, SEL_A1, 1'b0, 1'b1, DST_K2,   1'b0);
         // squared length of r
         5'd25: u = ocr_mk(SEL_K0, SEL_K0, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd26: u = ocr_mk(SEL_K1, SEL_K1, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd27: u = ocr_mk(SEL_K2, SEL_K2, 1'b0, 1'b0, DST_N2,   1'b1);
         default: u = ocr_mk(SEL_P0, SEL_P0, 1'b1, 1'b0, DST_NONE, 1'b1);
      endcase
      return u;
   endfunction

endpackage

/* rtl/ocr_if.sv */
`timescale 1ns / 1ps

// input word: one arrow press
interface ocr_req_if;
   import ocr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OCR_DIR_W-1:0] direction;
   modport source (output valid, output direction, input ready);
   modport sink (input valid, input direction, output ready);
endinterface

// result word: camera vectors after the step
interface ocr_rsp_if;
   import ocr_pkg::*;
   logic          valid;
   logic          ready;
   ocr_coord_type eye_x;
   ocr_coord_type eye_y;
   ocr_coord_type eye_z;
   ocr_coord_type up_x;
   ocr_coord_type up_y;
   ocr_coord_type up_z;
   logic          axis_degenerate;
   modport source (output valid, output eye_x, output eye_y, output eye_z, output up_x,
                   output up_y, output up_z, output axis_degenerate, input ready);
   modport sink (input valid, input eye_x, input eye_y, input eye_z, input up_x,
                 input up_y, input up_z, input axis_degenerate, output ready);
endinterface

// register write channel
interface ocr_csr_if;
   import ocr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [OCR_CSR_IDX_W-1:0] index;
   ocr_coord_type            data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/ocr_isqrt.sv */
`timescale 1ns / 1ps

// Integer square root, floor, one result bit per cycle.
module ocr_isqrt #(
   parameter int N_W = 44
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [N_W-1:0]         value,
   output logic                   done,
   output logic [(N_W+1)/2-1:0]   root
);

   localparam int R_W = (N_W + 1) / 2;
   localparam logic [N_W-1:0] BIT_TOP = N_W'(1) << (2 * (R_W - 1));

   logic [N_W-1:0] rem_ff;
   logic [N_W-1:0] res_ff;
   logic [N_W-1:0] bit_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [N_W:0]   trial;
   logic           fits;

   // trial subtrahend for this bit
   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign fits  = {1'b0, rem_ff} >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && bit_ff[0];
         if (start) begin
            rem_ff  <= value;
            res_ff  <= '0;
            bit_ff  <= BIT_TOP;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= rem_ff - trial[N_W-1:0];
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[R_W-1:0];

endmodule

/* rtl/orbit_camera_rotator_unit.sv */
`timescale 1ns / 1ps

// Orbit camera rotator. Holds the eye and up vectors (signed, FRAC_BITS fraction
// bits, reset to (0,0,1) and (0,1,0)) and turns them by the step angle whose cosine
// and sine sit in registers 0 and 1. Left/right turn the eye about up; up/down turn
// eye and up about the normalized (-eye) x up, flagging axis_degenerate and keeping
// the state when that axis is zero. All arithmetic runs on one multiply-accumulate
// unit stepped by a small program, plus a bit-serial square root and divider, and
// the block takes one press at a time. A degenerate axis ends the press right after
// the root. A finished word waits in the output register while the next press is
// already taken.
module orbit_camera_rotator_unit #(
   parameter int FRAC_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   ocr_req_if.sink     req_ch,
   ocr_rsp_if.source   rsp_ch,
   ocr_csr_if.sink     csr_ch
);

   import ocr_pkg::*;

   localparam int W     = OCR_W;
   localparam int F     = FRAC_BITS;
   localparam int RW    = 2 * W + 1 - F;
   localparam int OMC_W = ((F > W - 1) ? F : W - 1) + 3;
   localparam int QV_W  = RW + OMC_W - F + 1;
   localparam int MW0   = (QV_W > OMC_W) ? QV_W : OMC_W;
   localparam int MW    = (MW0 > W + 1) ? MW0 : W + 1;
   localparam int ACC_W = 2 * MW + 2;
   localparam int N2_W  = 2 * RW + 2;
   localparam int LEN_W = (N2_W + 1) / 2;
   localparam int QB    = F + 3;
   localparam int DV_W  = LEN_W + QB + 1;
   localparam int CNT_W = $clog2(QB);
   localparam int DQ_W  = (QB + 2 > W) ? QB + 2 : W;

   localparam logic signed [W-1:0]     ONE_SAT = (F >= W - 1) ? W'(OCR_VMAX) : W'(1 << F);
   localparam logic signed [MW-1:0]    ONE_M   = MW'(1) << F;
   localparam logic signed [ACC_W-1:0] HALF_A  = ACC_W'(1) << (F - 1);
   localparam logic signed [ACC_W-1:0] VMAX_A  = ACC_W'(OCR_VMAX);
   localparam logic signed [ACC_W-1:0] VMIN_A  = ACC_W'(OCR_VMIN);
   localparam logic signed [DQ_W-1:0]  VMAX_D  = DQ_W'(OCR_VMAX);
   localparam logic signed [DQ_W-1:0]  VMIN_D  = DQ_W'(OCR_VMIN);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_SQRT  = 3'd3;
   localparam logic [2:0] ST_DLOAD = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [OCR_PC_W-1:0]       pc_ff;
   logic                      tilt_ff;
   logic                      tgt_up_ff;
   logic                      axis_x_ff;
   logic                      degen_ff;
   logic                      rsp_valid_ff;

   logic signed [W-1:0]       cos_ff, sin_ff;
   logic signed [W-1:0]       eye_ff [3];
   logic signed [W-1:0]       up_ff [3];
   logic signed [W-1:0]       ax_ff [3];
   logic signed [MW-1:0]      k_ff [3];
   logic signed [MW-1:0]      d_ff, q_ff, s_ff, omc_ff;
   logic signed [2*MW-1:0]    prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;

   logic [LEN_W-1:0]          len_ff;
   logic [DV_W-1:0]           rem_ff, den_ff;
   logic [QB-1:0]             quo_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [1:0]                div_idx_ff;

   logic signed [W-1:0]       rsp_eye_ff [3];
   logic signed [W-1:0]       rsp_up_ff [3];
   logic                      rsp_degen_ff;

   ocr_uop_type               uop;
   logic signed [W-1:0]       pv [3];
   logic signed [W-1:0]       av [3];
   logic signed [MW-1:0]      opnd [OCR_SEL_N];
   logic signed [MW-1:0]      opa, opb;
   logic signed [ACC_W-1:0]   acc_base, prod_ext, acc_sum, rnd_val;
   logic signed [W-1:0]       sat_val;
   logic                      req_acc, csr_acc, rsp_free;
   logic                      is_tilt, is_neg;
   logic                      isq_start, isq_done;
   logic [LEN_W-1:0]          isq_root;
   logic                      dv_ge;
   logic [QB-1:0]             quo_in;
   logic signed [MW-1:0]      kdiv;
   logic                      kneg;
   logic [MW-1:0]             kmag;
   logic signed [DQ_W-1:0]    qs;
   logic signed [W-1:0]       ax_val;

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign csr_acc  = csr_ch.valid && csr_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign is_tilt  = (req_ch.direction == DIR_UP) || (req_ch.direction == DIR_DOWN);
   assign is_neg   = (req_ch.direction == DIR_RIGHT) || (req_ch.direction == DIR_DOWN);
   assign uop      = ocr_uop(pc_ff);

   // operand vectors: P is the vector being turned, A the axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pv[i] = tgt_up_ff ? up_ff[i] : eye_ff[i];
         av[i] = axis_x_ff ? ax_ff[i] : up_ff[i];
      end
   end

   // multiplier operand mux
   always_comb begin
      for (int i = 0; i < OCR_SEL_N; i++) begin
         opnd[i] = '0;
      end
      opnd[SEL_P0]  = MW'(pv[0]);
      opnd[SEL_P1]  = MW'(pv[1]);
      opnd[SEL_P2]  = MW'(pv[2]);
      opnd[SEL_A0]  = MW'(av[0]);
      opnd[SEL_A1]  = MW'(av[1]);
      opnd[SEL_A2]  = MW'(av[2]);
      opnd[SEL_K0]  = k_ff[0];
      opnd[SEL_K1]  = k_ff[1];
      opnd[SEL_K2]  = k_ff[2];
      opnd[SEL_D]   = d_ff;
      opnd[SEL_Q]   = q_ff;
      opnd[SEL_C]   = MW'(cos_ff);
      opnd[SEL_S]   = s_ff;
      opnd[SEL_OMC] = omc_ff;
   end

   assign opa = opnd[uop.a_sel];
   assign opb = opnd[uop.b_sel];

   // accumulate, round to nearest (ties up), saturate
   always_comb begin
      acc_base = uop.first ? '0 : acc_ff;
      prod_ext = ACC_W'(prod_ff);
      acc_sum  = uop.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
      rnd_val  = (acc_sum + HALF_A) >>> F;
      if (rnd_val > VMAX_A) begin
         sat_val = W'(OCR_VMAX);
      end else if (rnd_val < VMIN_A) begin
         sat_val = W'(OCR_VMIN);
      end else begin
         sat_val = rnd_val[W-1:0];
      end
   end

   // square root of the tilt axis length squared
   assign isq_start = (state_ff == ST_ACC) && uop.last && (uop.dst == DST_N2);

   ocr_isqrt #(
      .N_W (N2_W)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (isq_start),
      .value (acc_sum[N2_W-1:0]),
      .done  (isq_done),
      .root  (isq_root)
   );

   // restoring divide step and axis component
   always_comb begin
      dv_ge  = rem_ff >= den_ff;
      quo_in = {quo_ff[QB-2:0], dv_ge};
      kdiv   = k_ff[div_idx_ff];
      kneg   = kdiv[MW-1];
      kmag   = kneg ? -kdiv : kdiv;
      qs     = kneg ? -signed'(DQ_W'(quo_in)) : signed'(DQ_W'(quo_in));
      if (qs > VMAX_D) begin
         ax_val = W'(OCR_VMAX);
      end else if (qs < VMIN_D) begin
         ax_val = W'(OCR_VMIN);
      end else begin
         ax_val = qs[W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (!uop.last) begin
               state_in = ST_MUL;
            end else if (uop.dst == DST_N2) begin
               state_in = ST_SQRT;
            end else if (tilt_ff && !tgt_up_ff) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SQRT: begin
            if (isq_done) state_in = (isq_root == '0) ? ST_DONE : ST_DLOAD;
         end
         ST_DLOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(QB - 1)) state_in = (div_idx_ff == 2'd2) ? ST_MUL : ST_DLOAD;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cos_ff       <= W'(OCR_COS_RESET);
         sin_ff       <= W'(OCR_SIN_RESET);
         eye_ff[0]    <= '0;
         eye_ff[1]    <= '0;
         eye_ff[2]    <= ONE_SAT;
         up_ff[0]     <= '0;
         up_ff[1]     <= ONE_SAT;
         up_ff[2]     <= '0;
      end else begin
         state_ff <= state_in;

         // register writes
         if (csr_acc) begin
            unique case (csr_ch.index)
               CSR_COS: cos_ff <= csr_ch.data;
               CSR_SIN: sin_ff <= csr_ch.data;
               default: ;
            endcase
         end

         // word taken and no new word loaded behind it
         if (rsp_ch.valid && rsp_ch.ready && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  pc_ff     <= is_tilt ? PC_TILT : PC_ROT;
                  tilt_ff   <= is_tilt;
                  tgt_up_ff <= 1'b0;
                  axis_x_ff <= 1'b0;
                  degen_ff  <= 1'b0;
                  s_ff      <= is_neg ? -MW'(sin_ff) : MW'(sin_ff);
                  omc_ff    <= ONE_M - MW'(cos_ff);
               end
            end
            ST_MUL: begin
               prod_ff <= opa * opb;
            end
            ST_ACC: begin
               acc_ff <= acc_sum;
               unique case (uop.dst)
                  DST_K0: k_ff[0] <= rnd_val[MW-1:0];
                  DST_K1: k_ff[1] <= rnd_val[MW-1:0];
                  DST_K2: k_ff[2] <= rnd_val[MW-1:0];
                  DST_D:  d_ff    <= rnd_val[MW-1:0];
                  DST_Q:  q_ff    <= rnd_val[MW-1:0];
                  DST_P0: if (tgt_up_ff) up_ff[0] <= sat_val; else eye_ff[0] <= sat_val;
                  DST_P1: if (tgt_up_ff) up_ff[1] <= sat_val; else eye_ff[1] <= sat_val;
                  DST_P2: if (tgt_up_ff) up_ff[2] <= sat_val; else eye_ff[2] <= sat_val;
                  default: ;
               endcase
               if (!uop.last) begin
                  pc_ff <= pc_ff + 1'b1;
               end else if ((uop.dst != DST_N2) && tilt_ff && !tgt_up_ff) begin
                  // eye done, now turn up about the same axis
                  tgt_up_ff <= 1'b1;
                  pc_ff     <= PC_ROT;
               end
            end
            ST_SQRT: begin
               div_idx_ff <= 2'd0;
               if (isq_done) begin
                  len_ff <= isq_root;
                  if (isq_root == '0) degen_ff <= 1'b1;
               end
            end
            ST_DLOAD: begin
               rem_ff <= (DV_W'(kmag) << F) + DV_W'(len_ff >> 1);
               den_ff <= DV_W'(len_ff) << (QB - 1);
               quo_ff <= '0;
               cnt_ff <= '0;
            end
            ST_DIV: begin
               if (dv_ge) rem_ff <= rem_ff - den_ff;
               den_ff <= den_ff >> 1;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(QB - 1)) begin
                  ax_ff[div_idx_ff] <= ax_val;
                  if (div_idx_ff == 2'd2) begin
                     axis_x_ff <= 1'b1;
                     tgt_up_ff <= 1'b0;
                     pc_ff     <= PC_ROT;
                  end else begin
                     div_idx_ff <= div_idx_ff + 1'b1;
                  end
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_degen_ff <= degen_ff;
                  for (int i = 0; i < 3; i++) begin
                     rsp_eye_ff[i] <= eye_ff[i];
                     rsp_up_ff[i]  <= up_ff[i];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // ports
   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign csr_ch.ready           = 1'b1;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.eye_x           = rsp_eye_ff[0];
   assign rsp_ch.eye_y           = rsp_eye_ff[1];
   assign rsp_ch.eye_z           = rsp_eye_ff[2];
   assign rsp_ch.up_x            = rsp_up_ff[0];
   assign rsp_ch.up_y            = rsp_up_ff[1];
   assign rsp_ch.up_z            = rsp_up_ff[2];
   assign rsp_ch.axis_degenerate = rsp_degen_ff;

   // checks
   a_div_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (len_ff != '0))
      else $error("divide running with zero axis length");

   a_turn_not_degen: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && !tilt_ff) |-> !degen_ff)
      else $error("left/right word flagged degenerate");

   a_root_done_waited: assert property (@(posedge clock) disable iff (reset)
      isq_done |-> (state_ff == ST_SQRT))
      else $error("root finished outside its wait state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result word raised outside completion");

endmodule
